### hw/rtl/can_stdio_link_endpoint_core_macros.svh
// assertion helpers shared by the link endpoint rtl
`ifndef CAN_STDIO_LINK_ENDPOINT_CORE_MACROS_SVH
`define CAN_STDIO_LINK_ENDPOINT_CORE_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge out of reset
`define CSLE_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("csle assertion failed");
// expression must never be true out of reset
`define CSLE_ASSERT_NEVER(name, clk, rstn, expr) \
  `CSLE_ASSERT(name, clk, rstn, !(expr))
`else
`define CSLE_ASSERT(name, clk, rstn, prop)
`define CSLE_ASSERT_NEVER(name, clk, rstn, expr)
`endif

`endif

### hw/rtl/csle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package csle_pkg;

  // sizes
  localparam int unsigned FIFO_DEPTH_DEF = 16;
  localparam int unsigned PUSH_LANES     = 7;
  localparam int unsigned SEND_LANES     = 6;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 14;
  localparam int unsigned TIMEOUT_W      = 14;
  localparam int unsigned NODE_ID_W      = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NODE_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd1;

  // reset values and special codes
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST  = 14'd10000;
  localparam logic [TIMEOUT_W-1:0] WAIT_MAX     = 14'h3FFF;
  localparam logic [7:0]           CODE_UPDATE  = 8'd254;
  localparam logic [7:0]           CODE_CLOSE   = 8'd255;
  localparam int unsigned          CTS_BIT      = 7;
  localparam logic [2:0]           SEND_MAX_LEN = 3'd6;

  typedef enum logic [1:0] {
    MODE_FRAME = 2'd0,
    MODE_READ  = 2'd1,
    MODE_SEND  = 2'd2,
    MODE_TICK  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_CHAR   = 3'd1,
    EV_SENT   = 3'd2,
    EV_DONE   = 3'd3,
    EV_FAIL   = 3'd4,
    EV_UPDATE = 3'd5,
    EV_BUSY   = 3'd6
  } ev_e;

  typedef struct packed {
    mode_e                       mode;
    logic [7:0]                  len_code;
    logic [7:0]                  seq_in;
    logic [PUSH_LANES-1:0][7:0]  rx_bytes;
  } in_item_t;

  typedef struct packed {
    ev_e                         event_res;
    logic [7:0]                  char_out;
    logic [7:0]                  tx_seq;
    logic [7:0]                  tx_len;
    logic [SEND_LANES-1:0][7:0]  tx_bytes;
    logic                        connected;
    logic                        input_available;
  } out_item_t;

  typedef struct packed {
    logic                        push;
    logic                        flush;
    logic                        pop;
    logic [2:0]                  push_n;
    logic [PUSH_LANES-1:0][7:0]  bytes;
  } fifo_req_t;

  typedef struct packed {
    logic                        empty;
    logic                        avail_next;
    logic [7:0]                  rd_data;
  } fifo_sts_t;

endpackage

`default_nettype wire

### hw/rtl/csle_intf.sv
`timescale 1ns / 1ps
`default_nettype none

// request channel into the endpoint
interface csle_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] len_code;
  logic [7:0] seq_in;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;
  logic [7:0] byte4;
  logic [7:0] byte5;
  logic [7:0] byte6;

  modport source (
    output valid, mode, len_code, seq_in, byte0, byte1, byte2, byte3, byte4, byte5, byte6,
    input  ready
  );
  modport sink (
    input  valid, mode, len_code, seq_in, byte0, byte1, byte2, byte3, byte4, byte5, byte6,
    output ready
  );
endinterface

// result channel out of the endpoint
interface csle_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] char_out;
  logic [7:0] tx_seq;
  logic [7:0] tx_len;
  logic [7:0] tx_byte0;
  logic [7:0] tx_byte1;
  logic [7:0] tx_byte2;
  logic [7:0] tx_byte3;
  logic [7:0] tx_byte4;
  logic [7:0] tx_byte5;
  logic       connected;
  logic       input_available;

  modport source (
    output valid, event_res, char_out, tx_seq, tx_len, tx_byte0, tx_byte1, tx_byte2,
           tx_byte3, tx_byte4, tx_byte5, connected, input_available,
    input  ready
  );
  modport sink (
    input  valid, event_res, char_out, tx_seq, tx_len, tx_byte0, tx_byte1, tx_byte2,
           tx_byte3, tx_byte4, tx_byte5, connected, input_available,
    output ready
  );
endinterface

// register write channel
interface csle_cfg_if;
  import csle_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/csle_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module csle_fifo #(
  parameter int unsigned FIFO_DEPTH = csle_pkg::FIFO_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  csle_pkg::fifo_req_t req_i,
  output csle_pkg::fifo_sts_t sts_o
);
  import csle_pkg::*;

  localparam int unsigned IW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam logic [SW-1:0] DEPTH_W = SW'(FIFO_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(FIFO_DEPTH - 1);

  logic [7:0]    mem_q [FIFO_DEPTH];
  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [SW-1:0] tail_sum, tail_w, space;
  logic [2:0]    take;
  logic [SW-1:0] pos [PUSH_LANES];
  logic          lane_we [PUSH_LANES];

  // write positions for the push lanes, bytes beyond free space are dropped
  always_comb begin
    tail_sum = SW'(head_q) + SW'(count_q);
    tail_w   = (tail_sum >= DEPTH_W) ? (tail_sum - DEPTH_W) : tail_sum;
    space    = DEPTH_W - SW'(count_q);
    take     = (SW'(req_i.push_n) <= space) ? req_i.push_n : space[2:0];
    for (int k = 0; k < PUSH_LANES; k++) begin
      pos[k] = tail_w + SW'(k);
      if (pos[k] >= DEPTH_W) begin
        pos[k] = pos[k] - DEPTH_W;
      end
      lane_we[k] = req_i.push && (3'(k) < take);
    end
  end

  // pointer and fill count update
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (req_i.flush) begin
      head_d  = '0;
      count_d = '0;
    end else if (req_i.push) begin
      count_d = count_q + CW'(take);
    end else if (req_i.pop && (count_q != '0)) begin
      head_d  = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < PUSH_LANES; k++) begin
      if (lane_we[k]) begin
        mem_q[pos[k][IW-1:0]] <= req_i.bytes[k];
      end
    end
  end

  assign sts_o.empty      = (count_q == '0);
  assign sts_o.avail_next = (count_d != '0);
  assign sts_o.rd_data    = mem_q[head_q];

endmodule

`default_nettype wire

### hw/rtl/csle_link.sv
`timescale 1ns / 1ps
`default_nettype none

module csle_link (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  acc_i,
  input  csle_pkg::in_item_t                    item_i,
  input  logic [csle_pkg::NODE_ID_W-1:0]        node_id_i,
  input  logic [csle_pkg::TIMEOUT_W-1:0]        timeout_i,
  input  csle_pkg::fifo_sts_t                   fifo_sts_i,
  output csle_pkg::fifo_req_t                   fifo_req_o,
  output csle_pkg::out_item_t                   res_o
);
  import csle_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_WAIT_CTS = 2'd1,
    PH_WAIT_ACK = 2'd2
  } phase_e;

  phase_e                     phase_q, phase_d;
  logic                       link_q, link_d;
  logic                       peer_rdy_q, peer_rdy_d;
  logic [7:0]                 last_ack_q, last_ack_d;
  logic [7:0]                 pend_seq_q, pend_seq_d;
  logic [2:0]                 pend_len_q, pend_len_d;
  logic [SEND_LANES-1:0][7:0] pend_bytes_q, pend_bytes_d;
  logic [TIMEOUT_W-1:0]       wait_q, wait_d;
  logic [TIMEOUT_W-1:0]       wait_inc, limit;
  logic [2:0]                 send_n;
  logic                       emit;
  logic                       upd;
  ev_e                        ev;

  // next state and result for one request
  always_comb begin
    phase_d      = phase_q;
    link_d       = link_q;
    peer_rdy_d   = peer_rdy_q;
    last_ack_d   = last_ack_q;
    pend_seq_d   = pend_seq_q;
    pend_len_d   = pend_len_q;
    pend_bytes_d = pend_bytes_q;
    wait_d       = wait_q;
    emit         = 1'b0;
    upd          = 1'b0;
    ev           = EV_NONE;
    res_o        = '0;
    fifo_req_o   = '0;
    fifo_req_o.bytes = item_i.rx_bytes;
    send_n       = (item_i.len_code > 8'(SEND_MAX_LEN)) ? SEND_MAX_LEN : item_i.len_code[2:0];
    wait_inc     = (wait_q != WAIT_MAX) ? wait_q + 1'b1 : wait_q;
    limit        = (timeout_i == '0) ? TIMEOUT_W'(1) : timeout_i;

    case (item_i.mode)
      MODE_FRAME: begin
        if (item_i.len_code == CODE_UPDATE) begin
          upd = 1'b1;
        end else if (item_i.len_code == CODE_CLOSE) begin
          link_d           = 1'b0;
          fifo_req_o.flush = acc_i;
        end else begin
          peer_rdy_d        = !item_i.len_code[CTS_BIT];
          link_d            = 1'b1;
          fifo_req_o.push   = acc_i;
          fifo_req_o.push_n = item_i.len_code[2:0];
        end
        last_ack_d = item_i.seq_in;
        // advance a pending send with the updated link view
        case (phase_q)
          PH_WAIT_ACK: begin
            if (last_ack_d == pend_seq_q) begin
              phase_d = PH_IDLE;
              ev      = EV_DONE;
            end else if (!link_d) begin
              phase_d = PH_IDLE;
              ev      = EV_FAIL;
            end
          end
          PH_WAIT_CTS: begin
            if (!link_d) begin
              phase_d = PH_IDLE;
              ev      = EV_FAIL;
            end else if (peer_rdy_d) begin
              emit = 1'b1;
            end
          end
          default: ;
        endcase
      end
      MODE_READ: begin
        fifo_req_o.pop = acc_i;
        ev             = EV_CHAR;
        res_o.char_out = fifo_sts_i.empty ? 8'd0 : fifo_sts_i.rd_data;
      end
      MODE_SEND: begin
        if (phase_q != PH_IDLE) begin
          ev = EV_BUSY;
        end else if (link_q && (item_i.len_code != 8'd0)) begin
          pend_len_d = send_n;
          pend_seq_d = last_ack_q + 8'd1;
          for (int i = 0; i < SEND_LANES; i++) begin
            pend_bytes_d[i] = (3'(i) < send_n) ? item_i.rx_bytes[i] : 8'd0;
          end
          wait_d = '0;
          if (peer_rdy_q) begin
            emit = 1'b1;
          end else begin
            phase_d = PH_WAIT_CTS;
          end
        end
      end
      MODE_TICK: begin
        if (phase_q != PH_IDLE) begin
          if (wait_inc >= limit) begin
            link_d  = 1'b0;
            phase_d = PH_IDLE;
            wait_d  = '0;
            ev      = EV_FAIL;
          end else begin
            wait_d = wait_inc;
          end
        end
      end
      default: ;
    endcase

    // frame goes out on the bus
    if (emit) begin
      phase_d = PH_WAIT_ACK;
      wait_d  = '0;
      ev      = EV_SENT;
    end

    // update request overrides the send event and blanks the frame fields
    if (upd) begin
      ev = EV_UPDATE;
    end else if (emit) begin
      res_o.tx_seq   = pend_seq_d;
      res_o.tx_len   = {node_id_i, 1'b0, pend_len_d};
      res_o.tx_bytes = pend_bytes_d;
    end

    res_o.event_res       = ev;
    res_o.connected       = link_d;
    res_o.input_available = fifo_sts_i.avail_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      link_q     <= 1'b0;
      peer_rdy_q <= 1'b1;
      last_ack_q <= '0;
      pend_seq_q <= '0;
      pend_len_q <= '0;
      wait_q     <= '0;
    end else if (acc_i) begin
      phase_q    <= phase_d;
      link_q     <= link_d;
      peer_rdy_q <= peer_rdy_d;
      last_ack_q <= last_ack_d;
      pend_seq_q <= pend_seq_d;
      pend_len_q <= pend_len_d;
      wait_q     <= wait_d;
    end
  end

  // chunk payload, written before any use
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      pend_bytes_q <= pend_bytes_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/can_stdio_link_endpoint_core.sv
`timescale 1ns / 1ps
`default_nettype none

`include "can_stdio_link_endpoint_core_macros.svh"

// channel   dir   handshake        payload
// in_i      in    valid / ready    mode, len_code, seq_in, byte0..byte6
// out_o     out   valid / ready    event_res, char_out, tx_*, connected, input_available
// cfg_i     in    valid / ready    index, data (0 node_id, 1 timeout_ticks)
//
// one request per cycle while in_i.ready is high; each request gives one result, valid in the cycle after acceptance
// all link and fifo state updates in the accept cycle, the result register holds the outcome
// in_i.ready drops only while a result waits and out_o.ready is low
// cfg_i is always ready; rst_ni clears link state, fifo pointers and the result valid
// receive fifo contents need no clearing pass after reset

module can_stdio_link_endpoint_core #(
  parameter int unsigned FIFO_DEPTH = csle_pkg::FIFO_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  csle_in_if.sink    in_i,
  csle_out_if.source out_o,
  csle_cfg_if.sink   cfg_i
);
  import csle_pkg::*;

  logic                 acc;
  logic                 in_ready;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q;
  out_item_t            res;
  in_item_t             item;
  fifo_req_t            fifo_req;
  fifo_sts_t            fifo_sts;
  logic [NODE_ID_W-1:0] node_id_q;
  logic [TIMEOUT_W-1:0] timeout_q;

  // input handshake
  assign in_ready   = !out_valid_q || out_o.ready;
  assign in_i.ready = in_ready;
  assign acc        = in_i.valid && in_ready;

  always_comb begin
    item.mode        = mode_e'(in_i.mode);
    item.len_code    = in_i.len_code;
    item.seq_in      = in_i.seq_in;
    item.rx_bytes[0] = in_i.byte0;
    item.rx_bytes[1] = in_i.byte1;
    item.rx_bytes[2] = in_i.byte2;
    item.rx_bytes[3] = in_i.byte3;
    item.rx_bytes[4] = in_i.byte4;
    item.rx_bytes[5] = in_i.byte5;
    item.rx_bytes[6] = in_i.byte6;
  end

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q <= '0;
      timeout_q <= TIMEOUT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_NODE_ID: node_id_q <= cfg_i.data[NODE_ID_W-1:0];
        REG_TIMEOUT: timeout_q <= cfg_i.data[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  csle_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fifo_req),
    .sts_o  (fifo_sts)
  );

  csle_link u_link (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .item_i     (item),
    .node_id_i  (node_id_q),
    .timeout_i  (timeout_q),
    .fifo_sts_i (fifo_sts),
    .fifo_req_o (fifo_req),
    .res_o      (res)
  );

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (acc) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      out_q <= res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.event_res       = out_q.event_res;
  assign out_o.char_out        = out_q.char_out;
  assign out_o.tx_seq          = out_q.tx_seq;
  assign out_o.tx_len          = out_q.tx_len;
  assign out_o.tx_byte0        = out_q.tx_bytes[0];
  assign out_o.tx_byte1        = out_q.tx_bytes[1];
  assign out_o.tx_byte2        = out_q.tx_bytes[2];
  assign out_o.tx_byte3        = out_q.tx_bytes[3];
  assign out_o.tx_byte4        = out_q.tx_bytes[4];
  assign out_o.tx_byte5        = out_q.tx_bytes[5];
  assign out_o.connected       = out_q.connected;
  assign out_o.input_available = out_q.input_available;

  // checks
  `CSLE_ASSERT(a_acc_gives_result, clk_i, rst_ni, acc |=> out_valid_q)
  `CSLE_ASSERT(a_read_gives_char, clk_i, rst_ni, acc && (item.mode == MODE_READ) |=> out_q.event_res == EV_CHAR)
  `CSLE_ASSERT(a_fail_drops_link, clk_i, rst_ni, out_valid_q && (out_q.event_res == EV_FAIL) |-> !out_q.connected)
  `CSLE_ASSERT_NEVER(a_sent_while_down, clk_i, rst_ni, out_valid_q && (out_q.event_res == EV_SENT) && !out_q.connected)

endmodule

`default_nettype wire
